### src/kmer_window_scan_scorer_macros.svh
// ----------------------------------------------------------------------------
// kmer_window_scan_scorer_macros
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef KMER_WINDOW_SCAN_SCORER_MACROS_SVH
`define KMER_WINDOW_SCAN_SCORER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define KWS_ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define KWS_ASSERT(lbl, prop, msg) `KWS_ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

### src/kws_pkg.sv
// ----------------------------------------------------------------------------
// kws_pkg
// Types and constants shared by the k-mer window scorer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kws_pkg;

	localparam int FEATURE_SLOTS = 256;
	localparam int SLOT_W        = 8;
	localparam int WINDOW_MAX    = 64;
	localparam int WIN_W         = 7;
	localparam int HIST_W        = 2 * WINDOW_MAX;
	localparam int KMER_MAX      = 8;
	localparam int SUM_W         = 26;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_WRITE = 2'd1,
		OP_CHAR  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic CFG_BIAS   = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam logic signed [24:0] SCORE_MIN = 25'sh1000000;
	localparam logic signed [24:0] SCORE_MAX = 25'sh0FFFFFF;

	typedef struct packed {
		op_t                op;
		logic [7:0]         slot;
		logic [5:0]         offset;
		logic [3:0]         len;
		logic [15:0]        kmer;
		logic signed [15:0] weight;
		logic [1:0]         base;
		logic               bad;
		logic               last;
	} kws_item_t;

	typedef struct packed {
		logic [5:0]  offset;
		logic [3:0]  len;
		logic [15:0] kmer;
		logic [15:0] weight;
	} kws_feat_t;

	localparam int FEAT_W = $bits(kws_feat_t);

endpackage

`default_nettype wire

### src/kws_ram.sv
// ----------------------------------------------------------------------------
// kws_ram
// Generic single write, single read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/kws_front.sv
// ----------------------------------------------------------------------------
// kws_front
// Accepts input items, decodes characters to bases and queues the items.
// ----------------------------------------------------------------------------
`default_nettype none

module kws_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         op,
	input  wire logic [7:0]         slot,
	input  wire logic [5:0]         feat_offset,
	input  wire logic [3:0]         feat_len,
	input  wire logic [15:0]        feat_kmer,
	input  wire logic signed [15:0] feat_weight,
	input  wire logic [7:0]         char_code,
	input  wire logic               last,
	output logic                    q_valid,
	output kws_pkg::kws_item_t      q_item,
	input  wire logic               q_take
);
	import kws_pkg::*;

	kws_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [7:0] upper;
	kws_item_t  item;
	logic       wr_en;

	always_comb begin
		upper = char_code;
		if (char_code >= CH_LOW_A && char_code <= CH_LOW_Z) begin
			upper = char_code - CASE_GAP;
		end
		item        = '0;
		item.op     = op_t'(op);
		item.slot   = slot;
		item.offset = feat_offset;
		item.len    = feat_len;
		item.kmer   = feat_kmer;
		item.weight = feat_weight;
		item.last   = last;
		item.bad    = 1'b0;
		unique case (upper)
			CH_A: item.base = BASE_A;
			CH_C: item.base = BASE_C;
			CH_G: item.base = BASE_G;
			CH_T: item.base = BASE_T;
			default: begin
				item.base = BASE_A;
				item.bad  = 1'b1;
			end
		endcase
	end

	assign full    = (count_q == 2'd2);
	assign wr_en   = push && !full;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, q_take};
		end
	end

endmodule

`default_nettype wire

### src/kws_back.sv
// ----------------------------------------------------------------------------
// kws_back
// Holds the feature table and base history, scores windows on both strands
// by sweeping the table, and keeps the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kws_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               q_valid,
	input  wire kws_pkg::kws_item_t q_item,
	output logic                    q_take,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [24:0]      max_score,
	output logic                    status
);
	import kws_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_FINISH} state_t;

	state_t                  state_q;
	logic signed [15:0]      bias_q;
	logic [WIN_W-1:0]        win_q;
	logic [HIST_W-1:0]       hist_q;
	logic [WIN_W-1:0]        chars_q;
	logic signed [24:0]      best_q;
	logic                    bad_q;
	logic                    last_pend_q;
	logic [FEATURE_SLOTS-1:0] valid_bits_q;
	logic [SLOT_W-1:0]       idx_q;
	logic                    issue_q;
	logic                    vld_s1;
	logic                    vbit_s1;
	logic                    end_s1;
	logic signed [SUM_W-1:0] sum_f_q;
	logic signed [SUM_W-1:0] sum_r_q;
	logic                    out_valid_q;
	logic signed [24:0]      max_score_q;
	logic                    status_q;

	logic [WIN_W-1:0]        len_eff;
	logic [FEAT_W-1:0]       rdata;
	kws_feat_t               feat;
	logic                    ram_we;
	logic [7:0]              off8, k8, len8, fsh;
	logic                    usable;
	logic [15:0]             mask, fwd_bits, rwin, rrev, rev_bits;
	logic [HIST_W-1:0]       fsh_hist, rsh_hist;
	logic                    hit_f, hit_r;
	logic signed [SUM_W-1:0] w_ext;
	logic [WIN_W-1:0]        chars_n;
	logic signed [24:0]      sat_f, sat_r, best_n;

	always_comb begin
		len_eff = win_q;
		if (win_q == '0) begin
			len_eff = WIN_W'(1);
		end else if (win_q > WIN_W'(WINDOW_MAX)) begin
			len_eff = WIN_W'(WINDOW_MAX);
		end
	end

	assign q_take = q_valid && (state_q == ST_IDLE);
	assign ram_we = q_take && (q_item.op == OP_WRITE);

	kws_ram #(
		.WIDTH(FEAT_W),
		.DEPTH(FEATURE_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_item.slot),
		.wdata({q_item.offset, q_item.len, q_item.kmer, q_item.weight}),
		.raddr(idx_q),
		.rdata(rdata)
	);

	// Match of one table entry against the current window on both strands.
	always_comb begin
		feat   = kws_feat_t'(rdata);
		off8   = {2'b00, feat.offset};
		k8     = {4'b0000, feat.len};
		len8   = {1'b0, len_eff};
		usable = vbit_s1 && (feat.len != 4'd0) && (k8 <= 8'(KMER_MAX))
			&& ((off8 + k8) <= len8);
		mask   = 16'((17'd1 << {feat.len, 1'b0}) - 17'd1);
		fsh    = len8 - off8 - k8;
		fsh_hist = hist_q >> {fsh, 1'b0};
		fwd_bits = fsh_hist[15:0];
		rsh_hist = hist_q >> {off8, 1'b0};
		rwin     = rsh_hist[15:0];
		for (int j = 0; j < KMER_MAX; j++) begin
			rrev[2*(KMER_MAX-1-j) +: 2] = rwin[2*j +: 2];
		end
		rev_bits = (rrev >> {5'(KMER_MAX) - {1'b0, feat.len}, 1'b0}) ^ 16'hFFFF;
		hit_f    = usable && (((fwd_bits ^ feat.kmer) & mask) == 16'd0);
		hit_r    = usable && (((rev_bits ^ feat.kmer) & mask) == 16'd0);
		w_ext    = SUM_W'(signed'(feat.weight));
	end

	always_comb begin
		chars_n = chars_q;
		if (chars_q < WIN_W'(WINDOW_MAX)) begin
			chars_n = chars_q + WIN_W'(1);
		end
		if (sum_f_q > SUM_W'(SCORE_MAX)) begin
			sat_f = SCORE_MAX;
		end else if (sum_f_q < SUM_W'(SCORE_MIN)) begin
			sat_f = SCORE_MIN;
		end else begin
			sat_f = 25'(sum_f_q);
		end
		if (sum_r_q > SUM_W'(SCORE_MAX)) begin
			sat_r = SCORE_MAX;
		end else if (sum_r_q < SUM_W'(SCORE_MIN)) begin
			sat_r = SCORE_MIN;
		end else begin
			sat_r = 25'(sum_r_q);
		end
		best_n = best_q;
		if (sat_f > best_n) begin
			best_n = sat_f;
		end
		if (sat_r > best_n) begin
			best_n = sat_r;
		end
	end

	assign empty     = !out_valid_q;
	assign max_score = max_score_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bias_q       <= '0;
			win_q        <= WIN_W'(8);
			hist_q       <= '0;
			chars_q      <= '0;
			best_q       <= SCORE_MIN;
			bad_q        <= 1'b0;
			last_pend_q  <= 1'b0;
			valid_bits_q <= '0;
			idx_q        <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			vbit_s1      <= 1'b0;
			end_s1       <= 1'b0;
			sum_f_q      <= '0;
			sum_r_q      <= '0;
			out_valid_q  <= 1'b0;
			max_score_q  <= '0;
			status_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_BIAS) begin
					bias_q <= cfg_data;
				end else begin
					win_q <= cfg_data[WIN_W-1:0];
				end
			end
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			vld_s1  <= issue_q;
			vbit_s1 <= valid_bits_q[idx_q];
			end_s1  <= (idx_q == SLOT_W'(FEATURE_SLOTS - 1));
			unique case (state_q)
				ST_IDLE: begin
					if (q_take) begin
						unique case (q_item.op)
							OP_CLEAR: valid_bits_q <= '0;
							OP_WRITE: valid_bits_q[q_item.slot] <= (q_item.weight > 16'sd0);
							OP_CHAR: begin
								last_pend_q <= q_item.last;
								if (q_item.bad) begin
									bad_q <= 1'b1;
									if (q_item.last) begin
										state_q <= ST_FINISH;
									end
								end else if (!bad_q) begin
									hist_q  <= {hist_q[HIST_W-3:0], q_item.base};
									chars_q <= chars_n;
									if (chars_n >= len_eff) begin
										state_q <= ST_SCAN;
										idx_q   <= '0;
										issue_q <= 1'b1;
										sum_f_q <= SUM_W'(bias_q);
										sum_r_q <= SUM_W'(bias_q);
									end else if (q_item.last) begin
										state_q <= ST_FINISH;
									end
								end else if (q_item.last) begin
									state_q <= ST_FINISH;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						idx_q <= idx_q + SLOT_W'(1);
						if (idx_q == SLOT_W'(FEATURE_SLOTS - 1)) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						if (hit_f) begin
							sum_f_q <= sum_f_q + w_ext;
						end
						if (hit_r) begin
							sum_r_q <= sum_r_q + w_ext;
						end
						if (end_s1) begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					best_q  <= best_n;
					state_q <= last_pend_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					// A sequence with a bad character ends without a result.
					if (bad_q || !out_valid_q) begin
						if (!bad_q) begin
							out_valid_q <= 1'b1;
							if (chars_q < len_eff) begin
								max_score_q <= '0;
								status_q    <= 1'b1;
							end else begin
								max_score_q <= best_q;
								status_q    <= 1'b0;
							end
						end
						hist_q  <= '0;
						chars_q <= '0;
						best_q  <= SCORE_MIN;
						bad_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/kmer_window_scan_scorer.sv
// ----------------------------------------------------------------------------
// kmer_window_scan_scorer
// Positional k-mer window scorer: table loads and a base stream in, the best
// two-strand window score of each sequence out.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     push / full               op, slot, feat_*, char_code, last
// result    empty / pop               max_score, status
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Table writes, clears and characters that complete no window are taken in the
// scorer's idle state. A character that completes a window starts one sweep of
// the 256-entry feature memory through its single read port, then an update
// state. A sequence end passes a finish state that waits while the result
// register is full, unless the sequence held a bad character. A two-entry queue
// lets input transfers go on during a sweep. Reset clears the feature valid bits
// at once; no clearing pass is needed. The config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_window_scan_scorer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         op,
	input  wire logic [7:0]         slot,
	input  wire logic [5:0]         feat_offset,
	input  wire logic [3:0]         feat_len,
	input  wire logic [15:0]        feat_kmer,
	input  wire logic signed [15:0] feat_weight,
	input  wire logic [7:0]         char_code,
	input  wire logic               last,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [24:0]      max_score,
	output logic                    status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import kws_pkg::*;

	logic      q_valid;
	logic      q_take;
	kws_item_t q_item;

	assign cfg_ready = 1'b1;

	kws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.slot       (slot),
		.feat_offset(feat_offset),
		.feat_len   (feat_len),
		.feat_kmer  (feat_kmer),
		.feat_weight(feat_weight),
		.char_code  (char_code),
		.last       (last),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_take     (q_take)
	);

	kws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_take   (q_take),
		.empty    (empty),
		.pop      (pop),
		.max_score(max_score),
		.status   (status)
	);

endmodule

`default_nettype wire

### src/kws_checker.sv
// ----------------------------------------------------------------------------
// kws_checker
// Port-level checks on the k-mer window scorer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kmer_window_scan_scorer_macros.svh"

module kws_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [24:0] max_score,
	input wire logic               status,
	input wire logic               cfg_ready
);

	// A short sequence reports a zero score.
	`KWS_ASSERT(a_short_zero, (!empty && status) |-> (max_score == 25'sd0), "short seq nonzero")

	// A waiting result holds until its transfer.
	`KWS_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(max_score) && $stable(status)), "result changed")

	// The configuration port never stalls.
	`KWS_ASSERT(a_cfg_ready, cfg_ready, "config stalled")

endmodule

bind kmer_window_scan_scorer kws_checker u_kws_checker (.*);

`default_nettype wire

### dv/tb_kmer_window_scan_scorer.sv
// ----------------------------------------------------------------------------
// tb_kmer_window_scan_scorer
// Self-checking bench for the k-mer window scorer. A behavioural copy of the
// feature table and base history predicts each sequence result. Directed
// corner cases come first, then random table loads and sequences under
// several bias and window settings and idle patterns, and finally a long
// result stall that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_kmer_window_scan_scorer;
	import kws_pkg::*;

	localparam int  LIMIT_CYCLES = 3000000;
	localparam int  SETTLE       = 1000;
	localparam int  MAX_REPORTS  = 10;
	localparam logic signed [15:0] W_MAX_POS = 16'sh7FFF;
	localparam logic signed [15:0] W_MAX_NEG = 16'sh8000;

	typedef struct {
		logic signed [24:0] score;
		logic               short_seq;
	} score_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         op = OP_NONE;
	logic [7:0]         slot = '0;
	logic [5:0]         feat_offset = '0;
	logic [3:0]         feat_len = '0;
	logic [15:0]        feat_kmer = '0;
	logic signed [15:0] feat_weight = '0;
	logic [7:0]         char_code = '0;
	logic               last = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [24:0] max_score;
	logic               status;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = CFG_BIAS;
	logic [15:0]        cfg_data = '0;

	// Shadow state of the scorer.
	logic               tbl_valid [FEATURE_SLOTS];
	logic [5:0]         tbl_offset [FEATURE_SLOTS];
	logic [3:0]         tbl_len [FEATURE_SLOTS];
	logic [15:0]        tbl_kmer [FEATURE_SLOTS];
	logic signed [15:0] tbl_weight [FEATURE_SLOTS];
	logic [1:0]         bases [WINDOW_MAX];
	int                 bases_seen;
	longint             seq_best;
	bit                 seq_bad;
	logic signed [15:0] bias_reg;
	logic [6:0]         window_reg;

	score_rec_t         pending_scores [$];
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 hold_req = 0;
	int                 hold_left = 0;
	int                 items_sent = 0;
	int                 results_checked = 0;
	int                 mismatches = 0;
	int                 cycles = 0;

	kmer_window_scan_scorer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.slot        (slot),
		.feat_offset (feat_offset),
		.feat_len    (feat_len),
		.feat_kmer   (feat_kmer),
		.feat_weight (feat_weight),
		.char_code   (char_code),
		.last        (last),
		.empty       (empty),
		.pop         (pop),
		.max_score   (max_score),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				pending_scores.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random pop, or held low while a hold-off is running.
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		score_rec_t exp_rec;
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected result: max_score %0d status %0b", max_score, status);
			end else begin
				exp_rec = pending_scores.pop_front();
				if (max_score !== exp_rec.score || status !== exp_rec.short_seq) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("Result mismatch: expected score %0d status %0b, got %0d %0b",
							exp_rec.score, exp_rec.short_seq, max_score, status);
				end
			end
		end
	end

	function automatic int eff_window();
		if (window_reg == 0) return 1;
		if (window_reg > WINDOW_MAX) return WINDOW_MAX;
		return window_reg;
	endfunction

	function automatic longint strand_score(int len, bit rc);
		longint s;
		int     k;
		int     off;
		bit     hit;
		logic [1:0] want;
		logic [1:0] b;
		logic [15:0] kmer_sh;
		s = bias_reg;
		for (int i = 0; i < FEATURE_SLOTS; i++) begin
			if (!tbl_valid[i]) continue;
			k = tbl_len[i];
			off = tbl_offset[i];
			if (k == 0 || k > KMER_MAX || off + k > len) continue;
			hit = 1'b1;
			for (int j = 0; j < k; j++) begin
				kmer_sh = tbl_kmer[i] >> (2 * (k - 1 - j));
				want = kmer_sh[1:0];
				// The reverse strand reads the history oldest-last, complemented.
				b = rc ? 2'd3 - bases[off + j] : bases[len - 1 - off - j];
				if (b != want) hit = 1'b0;
			end
			if (hit) s += tbl_weight[i];
		end
		if (s > SCORE_MAX) s = SCORE_MAX;
		if (s < SCORE_MIN) s = SCORE_MIN;
		return s;
	endfunction

	function automatic void reset_sequence();
		foreach (bases[i]) bases[i] = BASE_A;
		bases_seen = 0;
		seq_best = SCORE_MIN;
		seq_bad = 1'b0;
	endfunction

	// Applies one accepted item to the shadow state and queues any result.
	function automatic void score_item(logic [1:0] o, logic [7:0] s, logic [5:0] off,
			logic [3:0] ln, logic [15:0] km, logic signed [15:0] w, logic [7:0] ch,
			logic lst);
		logic [7:0] c;
		int         code;
		int         len;
		longint     f;
		longint     r;
		score_rec_t rec;
		case (o)
			OP_CLEAR: begin
				foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
			end
			OP_WRITE: begin
				tbl_offset[s] = off;
				tbl_len[s] = ln;
				tbl_kmer[s] = km;
				tbl_weight[s] = w;
				tbl_valid[s] = (w > 0);
			end
			OP_CHAR: begin
				c = ch;
				len = eff_window();
				code = 4;
				if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_GAP;
				if (c == CH_A) code = BASE_A;
				else if (c == CH_C) code = BASE_C;
				else if (c == CH_G) code = BASE_G;
				else if (c == CH_T) code = BASE_T;
				if (code > 3) begin
					seq_bad = 1'b1;
				end else if (!seq_bad) begin
					for (int i = WINDOW_MAX - 1; i > 0; i--) bases[i] = bases[i - 1];
					bases[0] = 2'(code);
					if (bases_seen < WINDOW_MAX) bases_seen++;
					if (bases_seen >= len) begin
						f = strand_score(len, 1'b0);
						r = strand_score(len, 1'b1);
						if (f > seq_best) seq_best = f;
						if (r > seq_best) seq_best = r;
					end
				end
				if (lst) begin
					if (!seq_bad) begin
						rec.short_seq = (bases_seen < len);
						rec.score = rec.short_seq ? '0 : seq_best[24:0];
						pending_scores.push_back(rec);
					end
					reset_sequence();
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] o, logic [7:0] s, logic [5:0] off, logic [3:0] ln,
			logic [15:0] km, logic signed [15:0] w, logic [7:0] ch, logic lst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		op <= o;
		slot <= s;
		feat_offset <= off;
		feat_len <= ln;
		feat_kmer <= km;
		feat_weight <= w;
		char_code <= ch;
		last <= lst;
		do @(posedge clk); while (full);
		items_sent++;
		score_item(o, s, off, ln, km, w, ch, lst);
	endtask

	task automatic send_char(logic [7:0] ch, logic lst);
		send_item(OP_CHAR, $urandom, $urandom, $urandom, $urandom, $urandom, ch, lst);
	endtask

	task automatic send_feature(logic [7:0] s, logic [5:0] off, logic [3:0] ln,
			logic [15:0] km, logic signed [15:0] w);
		send_item(OP_WRITE, s, off, ln, km, w, $urandom, $urandom);
	endtask

	// Stops offering items and waits until every result has come back and any
	// trailing window sweep has finished.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BIAS) bias_reg = data;
		else window_reg = data[6:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] base_char();
		logic [7:0] ch;
		case ($urandom_range(0, 3))
			0: ch = CH_A;
			1: ch = CH_C;
			2: ch = CH_G;
			default: ch = CH_T;
		endcase
		if ($urandom_range(0, 1)) ch = ch + CASE_GAP;
		return ch;
	endfunction

	task automatic test_directed();
		send_feature(8'd0, 6'd0, 4'd1, 16'h0000, W_MAX_POS);
		send_feature(8'd255, 6'd63, 4'd8, 16'hFFFF, 16'sd1);
		send_feature(8'd1, 6'd1, 4'd1, 16'h0001, 16'sd256);
		// Two slots with the same feature both count.
		send_feature(8'd2, 6'd1, 4'd1, 16'h0001, 16'sd256);
		send_feature(8'd3, 6'd0, 4'd1, 16'h0000, 16'sd0);
		send_feature(8'd4, 6'd0, 4'd1, 16'h0000, W_MAX_NEG);
		send_feature(8'd5, 6'd0, 4'd0, 16'h0000, 16'sd100);
		send_feature(8'd6, 6'd0, 4'd15, 16'h0000, 16'sd100);
		// Only the low four bits of the k-mer are used: C then G.
		send_feature(8'd7, 6'd2, 4'd2, 16'hFFF6, 16'sd500);
		send_char("A", 1'b0);
		send_char("c", 1'b0);
		send_char("G", 1'b0);
		send_char("t", 1'b0);
		send_char("A", 1'b0);
		send_char("C", 1'b0);
		send_char("G", 1'b0);
		send_char("T", 1'b1);
		send_char("G", 1'b0);
		send_char("a", 1'b1);
		send_char("A", 1'b0);
		send_char("X", 1'b0);
		send_char("T", 1'b1);
		send_item(OP_NONE, 8'hFF, 6'h3F, 4'hF, 16'hFFFF, W_MAX_NEG, 8'hFF, 1'b1);
		send_item(OP_CLEAR, 8'h00, 6'h00, 4'h0, 16'h0000, 16'sd0, 8'h00, 1'b1);
	endtask

	task automatic test_random_traffic(int n_items);
		int target;
		int w;
		int seq_len;
		int r;
		target = items_sent + n_items;
		w = eff_window();
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			end else if (r < 7) begin
				send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			end else if (r < 40) begin
				if ($urandom_range(0, 9) < 8)
					send_feature($urandom, $urandom_range(0, w - 1), $urandom_range(1, 3),
						$urandom, $urandom_range(1, 2000));
				else
					send_feature($urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				seq_len = $urandom_range(1, w + 5);
				for (int i = 0; i < seq_len; i++) begin
					if ($urandom_range(0, 99) < 3)
						send_char($urandom_range(0, 255), i == seq_len - 1);
					else
						send_char(base_char(), i == seq_len - 1);
				end
			end
		end
	endtask

	task automatic test_config_sweep();
		send_idle_pct = 25;
		recv_idle_pct = 76;
		test_random_traffic(300);
		write_reg(CFG_WINDOW, 16'd0);
		write_reg(CFG_BIAS, 16'h8000);
		test_random_traffic(250);
		send_idle_pct = 76;
		recv_idle_pct = 25;
		write_reg(CFG_WINDOW, 16'd64);
		write_reg(CFG_BIAS, 16'h7FFF);
		test_random_traffic(300);
		write_reg(CFG_WINDOW, 16'd5);
		write_reg(CFG_BIAS, $urandom);
		test_random_traffic(350);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_WINDOW, 16'hFF81);
		write_reg(CFG_BIAS, $urandom);
		test_random_traffic(200);
		write_reg(CFG_WINDOW, 16'd3);
		write_reg(CFG_BIAS, 16'd0);
		test_random_traffic(250);
	endtask

	// Short sequences each give a result at once, so a long hold-off on the
	// result side backs the block up until it refuses input.
	task automatic test_result_stall();
		write_reg(CFG_WINDOW, 16'd8);
		hold_req = 3000;
		for (int i = 0; i < 40; i++) begin
			send_char(base_char(), 1'b0);
			send_char(base_char(), 1'b1);
		end
		drain();
	endtask

	initial begin
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 1'b0;
			tbl_offset[i] = '0;
			tbl_len[i] = '0;
			tbl_kmer[i] = '0;
			tbl_weight[i] = '0;
		end
		reset_sequence();
		bias_reg = '0;
		window_reg = 7'd8;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_config_sweep();
		test_result_stall();
		drain();

		if (pending_scores.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", pending_scores.size());
		end
		$display("Sent %0d items and checked %0d sequence results over six bias/window",
			items_sent, results_checked);
		$display("settings, three idle patterns and one long result stall; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/kws_pkg.sv
src/kws_ram.sv
src/kws_front.sv
src/kws_back.sv
src/kmer_window_scan_scorer.sv
src/kws_checker.sv
dv/tb_kmer_window_scan_scorer.sv
